@@ hdl/cvfq_pkg.sv @@
// ----------------------------------------------------------------------------
// cvfq_pkg
// Shared types, constants and helpers of the cell voltage fault qualifier.
// ----------------------------------------------------------------------------
package cvfq_pkg;

    localparam int NUM_CELLS   = 128;
    localparam int CELL_AW     = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int IDX_W       = 7;
    localparam int VOLT_W      = 16;
    localparam int COUNT_W     = 8;
    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 48;
    localparam int CFG_AW      = 4;
    localparam int CFG_DW      = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;

    localparam logic [VOLT_W-1:0]  OVER_LIMIT_RST  = 16'd4200;
    localparam logic [VOLT_W-1:0]  UNDER_LIMIT_RST = 16'd2800;
    localparam logic [COUNT_W-1:0] COUNT_LIMIT_RST = 8'd5;
    localparam logic [COUNT_W-1:0] COUNT_MAX       = 8'd255;

    localparam logic [1:0] REG_OVER_LIMIT  = 2'd0;
    localparam logic [1:0] REG_UNDER_LIMIT = 2'd1;
    localparam logic [1:0] REG_COUNT_LIMIT = 2'd2;

    typedef enum logic [1:0] {
        CLS_OK    = 2'd0,
        CLS_OVER  = 2'd1,
        CLS_UNDER = 2'd2
    } t_cls;

    typedef struct packed {
        logic [VOLT_W-1:0]  over_limit;
        logic [VOLT_W-1:0]  under_limit;
        logic [COUNT_W-1:0] count_limit;
    } t_cfg;

    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [VOLT_W-1:0] volt;
        logic              in_range;
        t_cls              cls;
    } t_item;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               kind;
        logic               over;
        logic               under;
    } t_entry;

    function automatic logic [CELL_AW-1:0] f_cell_addr(input logic [IDX_W-1:0] idx);
        logic [IDX_W+CELL_AW-1:0] ext;
        ext = {{CELL_AW{1'b0}}, idx};
        return ext[CELL_AW-1:0];
    endfunction

endpackage

@@ hdl/cvfq_ram.sv @@
// ----------------------------------------------------------------------------
// cvfq_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module cvfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/cvfq_cfg.sv @@
// ----------------------------------------------------------------------------
// cvfq_cfg
// APB register bank holding the voltage limits and the count limit.
// ----------------------------------------------------------------------------
module cvfq_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cvfq_pkg::CFG_AW-1:0] paddr,
    input  logic [cvfq_pkg::CFG_DW-1:0] pwdata,
    output logic [cvfq_pkg::CFG_DW-1:0] prdata,
    output logic                        pready,
    output cvfq_pkg::t_cfg              o_cfg
);
    import cvfq_pkg::*;

    t_cfg       r_cfg;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.over_limit  <= OVER_LIMIT_RST;
            r_cfg.under_limit <= UNDER_LIMIT_RST;
            r_cfg.count_limit <= COUNT_LIMIT_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_OVER_LIMIT:  r_cfg.over_limit  <= pwdata[VOLT_W-1:0];
                REG_UNDER_LIMIT: r_cfg.under_limit <= pwdata[VOLT_W-1:0];
                REG_COUNT_LIMIT: r_cfg.count_limit <= pwdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_OVER_LIMIT:  prdata = {{(CFG_DW-VOLT_W){1'b0}}, r_cfg.over_limit};
            REG_UNDER_LIMIT: prdata = {{(CFG_DW-VOLT_W){1'b0}}, r_cfg.under_limit};
            REG_COUNT_LIMIT: prdata = {{(CFG_DW-COUNT_W){1'b0}}, r_cfg.count_limit};
            default:         prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

@@ hdl/cvfq_front.sv @@
// ----------------------------------------------------------------------------
// cvfq_front
// Input side: unpacks a sample, checks its index and classifies its voltage.
// ----------------------------------------------------------------------------
module cvfq_front (
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [cvfq_pkg::IN_DATA_W-1:0] s_axis_tdata,
    input  cvfq_pkg::t_cfg                 i_cfg,
    input  logic                           i_q_full,
    output logic                           o_push,
    output cvfq_pkg::t_item                o_item
);
    import cvfq_pkg::*;

    logic [IDX_W-1:0]  idx;
    logic [VOLT_W-1:0] volt;

    assign idx  = s_axis_tdata[IDX_W-1:0];
    assign volt = s_axis_tdata[IDX_W+VOLT_W-1:IDX_W];

    assign s_axis_tready = !i_q_full;
    assign o_push        = s_axis_tvalid && !i_q_full;

    always_comb begin
        o_item.idx      = idx;
        o_item.volt     = volt;
        o_item.in_range = (32'(idx) < NUM_CELLS);
        if (volt > i_cfg.over_limit) begin
            o_item.cls = CLS_OVER;
        end else if (volt < i_cfg.under_limit) begin
            o_item.cls = CLS_UNDER;
        end else begin
            o_item.cls = CLS_OK;
        end
    end

endmodule

@@ hdl/cvfq_queue.sv @@
// ----------------------------------------------------------------------------
// cvfq_queue
// Short FIFO of classified samples between the front and the back.
// ----------------------------------------------------------------------------
module cvfq_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cvfq_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output cvfq_pkg::t_item o_item
);
    import cvfq_pkg::*;

    t_item               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wptr;
    logic [QUEUE_AW-1:0] r_rptr;
    logic [QUEUE_AW:0]   r_count;

    assign o_full  = (32'(r_count) == QUEUE_DEPTH);
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ hdl/cvfq_back.sv @@
// ----------------------------------------------------------------------------
// cvfq_back
// Execution side: per-cell counter and latch update, pack flags, scan
// max/min and the output register.
// ----------------------------------------------------------------------------
module cvfq_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  cvfq_pkg::t_cfg                  i_cfg,
    input  logic                            i_q_valid,
    input  cvfq_pkg::t_item                 i_item,
    output logic                            o_pop,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [cvfq_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import cvfq_pkg::*;

    localparam int EW = $bits(t_entry);

    t_item                  r_u;
    logic                   r_u_valid;
    logic                   r_rd_vld;
    logic                   r_fwd_hit;
    t_entry                 r_fwd_data;
    logic [NUM_CELLS-1:0]   r_cell_vld;
    logic                   r_any_over;
    logic                   r_any_under;
    logic [VOLT_W-1:0]      r_max;
    logic [VOLT_W-1:0]      r_min;
    logic                   r_o_valid;
    logic [OUT_DATA_W-1:0]  r_o_data;

    logic [EW-1:0]          ram_rdata;
    logic [CELL_AW-1:0]     raddr;
    logic [CELL_AW-1:0]     waddr;
    logic                   we;
    logic                   u_adv;
    t_entry                 cur;
    t_entry                 n_entry;
    logic                   n_any_over;
    logic                   n_any_under;
    logic [VOLT_W-1:0]      n_max;
    logic [VOLT_W-1:0]      n_min;
    logic [OUT_DATA_W-1:0]  n_o_data;

    assign u_adv = r_u_valid && (!r_o_valid || m_axis_tready);
    assign o_pop = i_q_valid && (!r_u_valid || u_adv);
    assign raddr = f_cell_addr(i_item.idx);
    assign waddr = f_cell_addr(r_u.idx);
    assign we    = u_adv && r_u.in_range;

    cvfq_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_CELLS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (n_entry),
        .i_re    (o_pop),
        .i_raddr (raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        if (r_fwd_hit) begin
            cur = r_fwd_data;
        end else if (r_rd_vld) begin
            cur = t_entry'(ram_rdata);
        end else begin
            cur = '0;
        end

        n_entry = cur;
        case (r_u.cls)
            CLS_OVER: begin
                if (cur.count != COUNT_MAX) n_entry.count = cur.count + 1'b1;
                n_entry.kind = 1'b1;
            end
            CLS_UNDER: begin
                if (cur.count != COUNT_MAX) n_entry.count = cur.count + 1'b1;
                n_entry.kind = 1'b0;
            end
            default: begin
                if (cur.count != '0) n_entry.count = cur.count - 1'b1;
            end
        endcase

        n_any_over  = r_any_over;
        n_any_under = r_any_under;
        if (n_entry.count > i_cfg.count_limit) begin
            if (n_entry.kind) begin
                n_entry.over = 1'b1;
                n_any_over   = 1'b1;
            end else begin
                n_entry.under = 1'b1;
                n_any_under   = 1'b1;
            end
        end

        n_max = r_max;
        n_min = r_min;
        if (r_u.idx == '0) begin
            n_max = r_u.volt;
            n_min = r_u.volt;
        end else begin
            if (r_u.volt > r_max) n_max = r_u.volt;
            if (r_u.volt < r_min) n_min = r_u.volt;
        end

        if (!r_u.in_range) begin
            n_any_over  = r_any_over;
            n_any_under = r_any_under;
            n_max       = r_max;
            n_min       = r_min;
            n_o_data    = {4'b0000, {COUNT_W{1'b0}}, r_min, r_max,
                           r_any_under, r_any_over, 1'b0, 1'b0};
        end else begin
            n_o_data    = {4'b0000, n_entry.count, n_min, n_max,
                           n_any_under, n_any_over, n_entry.under, n_entry.over};
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_u        <= i_item;
            r_rd_vld   <= r_cell_vld[raddr];
            r_fwd_hit  <= we && (waddr == raddr);
            r_fwd_data <= n_entry;
        end
        if (u_adv) begin
            r_o_data <= n_o_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u_valid   <= 1'b0;
            r_o_valid   <= 1'b0;
            r_cell_vld  <= '0;
            r_any_over  <= 1'b0;
            r_any_under <= 1'b0;
            r_max       <= '0;
            r_min       <= '0;
        end else begin
            if (o_pop) begin
                r_u_valid <= 1'b1;
            end else if (u_adv) begin
                r_u_valid <= 1'b0;
            end
            if (u_adv) begin
                r_o_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
            if (we) begin
                r_cell_vld[waddr] <= 1'b1;
                r_any_over        <= n_any_over;
                r_any_under       <= n_any_under;
                r_max             <= n_max;
                r_min             <= n_min;
            end
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_data;

endmodule

@@ hdl/cell_voltage_fault_qualifier_core.sv @@
// ----------------------------------------------------------------------------
// cell_voltage_fault_qualifier_core
// Qualifies per-cell over/under voltage faults from a stream of samples.
//
// Usage:
//   s_axis carries one sample per word: cell index and voltage in mV.
//   m_axis returns one result word per sample: the cell's latched faults,
//   pack-wide fault flags, scan max/min and the cell's bad counter.
//   The APB port holds the over limit, under limit and count limit; write
//   it only while no sample is in flight.
// Timing:
//   A sample passes the queue, the update register and the output
//   register. One sample per cycle is sustained while m_axis_tready is
//   high; per-cell state lives in a one-read, one-write-port RAM, and a
//   back-to-back sample of the same cell reads its state from a bypass register.
// Reset:
//   Synchronous, active low. Clears all counters, latches, pack flags and
//   scan max/min (per-cell valid bits, no clearing sweep) and restores the
//   register defaults. Samples are accepted right after reset.
// Stall:
//   When m_axis_tready is low, the result holds, one more sample advances
//   into the back, two wait in the queue, then s_axis_tready drops.
// ----------------------------------------------------------------------------
module cell_voltage_fault_qualifier_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [6:0] cell_index, [22:7] cell_voltage, [23] zero
    input  logic [cvfq_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [0] cell_over_fault, [1] cell_under_fault, [2] pack_over_fault,
    // [3] pack_under_fault, [19:4] scan_max_mv, [35:20] scan_min_mv,
    // [43:36] bad_count, [47:44] zero
    output logic [cvfq_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cvfq_pkg::CFG_AW-1:0]     paddr,
    input  logic [cvfq_pkg::CFG_DW-1:0]     pwdata,
    output logic [cvfq_pkg::CFG_DW-1:0]     prdata,
    output logic                            pready
);
    import cvfq_pkg::*;

    t_cfg  cfg;
    t_item f_item;
    t_item q_item;
    logic  push;
    logic  pop;
    logic  q_full;
    logic  q_valid;

    cvfq_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    cvfq_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .i_cfg         (cfg),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_item        (f_item)
    );

    cvfq_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    cvfq_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_q_valid     (q_valid),
        .i_item        (q_item),
        .o_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

@@ dv/tb_cell_voltage_fault_qualifier_core.sv @@
// ----------------------------------------------------------------------------
// tb_cell_voltage_fault_qualifier_core
// Self-checking bench for the cell voltage fault qualifier. A queue of
// samples (directed corner cases, then scan-shaped random traffic) feeds a
// stream driver; a built-in fault predictor tracks per-cell counters,
// latches and scan max/min, and the monitor checks each result word field
// by field. Limits are rewritten over APB between phases while idle.
// ----------------------------------------------------------------------------
module tb_cell_voltage_fault_qualifier_core;
    timeunit 1ns;
    timeprecision 1ps;

    import cvfq_pkg::*;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         HOLD_CYCLES = 80;

    typedef struct packed {
        logic              pad;
        logic [VOLT_W-1:0] volt;
        logic [IDX_W-1:0]  cell_idx;
    } t_sample;

    typedef struct packed {
        logic [3:0]         pad;
        logic [COUNT_W-1:0] bad_count;
        logic [VOLT_W-1:0]  scan_min;
        logic [VOLT_W-1:0]  scan_max;
        logic               pack_under;
        logic               pack_over;
        logic               cell_under;
        logic               cell_over;
    } t_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_AW-1:0]     paddr = '0;
    logic [CFG_DW-1:0]     pwdata = '0;
    logic [CFG_DW-1:0]     prdata;
    logic                  pready;

    cell_voltage_fault_qualifier_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor state
    logic [VOLT_W-1:0]  lim_over = OVER_LIMIT_RST;
    logic [VOLT_W-1:0]  lim_under = UNDER_LIMIT_RST;
    logic [COUNT_W-1:0] lim_count = COUNT_LIMIT_RST;
    logic [COUNT_W-1:0] bad_cnt [NUM_CELLS] = '{default: '0};
    logic               kind_over [NUM_CELLS] = '{default: 1'b0};
    logic               latch_over [NUM_CELLS] = '{default: 1'b0};
    logic               latch_under [NUM_CELLS] = '{default: 1'b0};
    logic               pack_over = 1'b0;
    logic               pack_under = 1'b0;
    logic [VOLT_W-1:0]  scan_hi = '0;
    logic [VOLT_W-1:0]  scan_lo = '0;

    t_sample sample_queue[$];
    t_result expected_results[$];
    t_sample word_in_flight;
    int      samples_queued = 0;
    int      samples_sent = 0;
    int      results_seen = 0;
    int      mismatches = 0;
    int      hold_left = 0;
    bit      hold_done = 1'b0;
    int      idle_cycles = 0;
    int      next_cell = 0;
    int      scan_left = 0;

    function automatic t_result qualify_sample(t_sample s);
        t_result            r;
        logic [COUNT_W-1:0] c;
        r = '0;
        if (int'(s.cell_idx) < NUM_CELLS) begin
            c = bad_cnt[s.cell_idx];
            if (s.volt > lim_over) begin
                if (c != COUNT_MAX) c = c + 1'b1;
                kind_over[s.cell_idx] = 1'b1;
            end else if (s.volt < lim_under) begin
                if (c != COUNT_MAX) c = c + 1'b1;
                kind_over[s.cell_idx] = 1'b0;
            end else if (c != '0) begin
                c = c - 1'b1;
            end
            bad_cnt[s.cell_idx] = c;
            if (c > lim_count) begin
                if (kind_over[s.cell_idx]) begin
                    latch_over[s.cell_idx] = 1'b1;
                    pack_over = 1'b1;
                end else begin
                    latch_under[s.cell_idx] = 1'b1;
                    pack_under = 1'b1;
                end
            end
            if (s.cell_idx == '0) begin
                scan_hi = s.volt;
                scan_lo = s.volt;
            end else begin
                if (s.volt > scan_hi) scan_hi = s.volt;
                if (s.volt < scan_lo) scan_lo = s.volt;
            end
            r.cell_over  = latch_over[s.cell_idx];
            r.cell_under = latch_under[s.cell_idx];
            r.bad_count  = c;
        end
        r.pack_over  = pack_over;
        r.pack_under = pack_under;
        r.scan_max   = scan_hi;
        r.scan_min   = scan_lo;
        return r;
    endfunction

    task automatic report(input string msg);
        if (mismatches < 100) $display("MISMATCH: %s", msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report($sformatf("result %0d %s got %0d want %0d", results_seen, name, got, want));
    endtask

    task automatic queue_sample(input int cell_idx, input int volt);
        t_sample s;
        s = '0;
        s.cell_idx = cell_idx[IDX_W-1:0];
        s.volt     = volt[VOLT_W-1:0];
        sample_queue.push_back(s);
        samples_queued++;
    endtask

    function automatic int pick_voltage();
        int v;
        case ($urandom_range(9))
            0: v = $urandom_range(65535);
            1: v = int'(lim_over) + int'($urandom_range(6)) - 3;
            2: v = int'(lim_under) + int'($urandom_range(6)) - 3;
            3, 4, 5: v = $urandom_range(int'(lim_over), 65535);
            6, 7: v = $urandom_range(0, int'(lim_under));
            8: v = $urandom_range(1) ? 0 : 65535;
            default: v = $urandom_range(int'(lim_under), int'(lim_over));
        endcase
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return v;
    endfunction

    // scans restart at cell 0 and walk upward; some samples hit a random cell
    task automatic queue_random(input int n);
        int cell_idx;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(99) < 15) begin
                cell_idx = $urandom_range(NUM_CELLS - 1);
            end else if (scan_left == 0) begin
                cell_idx = 0;
                next_cell = 1;
                scan_left = $urandom_range(1, 10);
            end else begin
                cell_idx = next_cell;
                next_cell++;
                scan_left--;
            end
            queue_sample(cell_idx, pick_voltage());
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_DW-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_OVER_LIMIT:  lim_over = value[VOLT_W-1:0];
            REG_UNDER_LIMIT: lim_under = value[VOLT_W-1:0];
            REG_COUNT_LIMIT: lim_count = value[COUNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (samples_sent != samples_queued || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_limits(input int over, input int under, input int count);
        write_reg(REG_OVER_LIMIT, {16'($urandom_range(65535)), over[15:0]});
        write_reg(REG_UNDER_LIMIT, {16'($urandom_range(65535)), under[15:0]});
        write_reg(REG_COUNT_LIMIT, {16'($urandom_range(65535)), 8'h00, count[7:0]});
    endtask

    // sample driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_results.push_back(qualify_sample(word_in_flight));
                samples_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (sample_queue.size() > 0 &&
                    ((samples_sent >= 900 && samples_sent < 1200) ||
                     $urandom_range(99) >= 30)) begin
                    word_in_flight = sample_queue.pop_front();
                    s_axis_tdata  <= word_in_flight;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                results_seen++;
                if (expected_results.size() == 0) begin
                    report($sformatf("result %0d with no sample pending", results_seen));
                end else begin
                    want = expected_results.pop_front();
                    check_field("cell_over_fault", got.cell_over, want.cell_over);
                    check_field("cell_under_fault", got.cell_under, want.cell_under);
                    check_field("pack_over_fault", got.pack_over, want.pack_over);
                    check_field("pack_under_fault", got.pack_under, want.pack_under);
                    check_field("scan_max_mv", got.scan_max, want.scan_max);
                    check_field("scan_min_mv", got.scan_min, want.scan_min);
                    check_field("bad_count", got.bad_count, want.bad_count);
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (!hold_done && results_seen >= 500) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= (results_seen >= 900 && results_seen < 1200) ||
                                 $urandom_range(99) >= 30;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_cell_voltage_fault_qualifier_core: FAIL");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // before any restart, then limit edges, latching and strict count compare
        queue_sample(127, 3000);
        queue_sample(1, 0);
        queue_sample(0, 3000);
        queue_sample(127, 65535);
        queue_sample(2, 4200);
        queue_sample(2, 4201);
        queue_sample(3, 2800);
        queue_sample(3, 2799);
        repeat (6) queue_sample(4, 4500);
        queue_sample(4, 3000);
        repeat (5) queue_sample(6, 4201);
        queue_sample(0, 16'h5555);
        queue_sample(85, 16'haaaa);
        queue_sample(42, 4200);
        wait_idle();

        // lower count limit: cell 6 latches on an in-range sample
        write_limits(65535, 0, 0);
        queue_sample(6, 3000);
        queue_random(250);
        wait_idle();

        // crossed limits, counter saturation
        write_limits(0, 65535, 255);
        queue_sample(9, 0);
        queue_sample(9, 1);
        repeat (260) queue_sample(100, $urandom_range(1, 65535));
        wait_idle();
        write_reg(REG_COUNT_LIMIT, 32'd254);
        queue_sample(100, 5);
        queue_random(150);
        wait_idle();

        write_limits(4200, 2800, 5);
        queue_random(400);
        wait_idle();

        write_reg(REG_UNUSED, $urandom);
        for (int p = 0; p < 4; p++) begin
            write_limits($urandom_range(2000, 5000), $urandom_range(1500, 4000),
                         $urandom_range(0, 10));
            queue_random(200);
            wait_idle();
        end
        repeat (8) @(posedge i_clk);

        while (expected_results.size() > 0) begin
            report("expected result never arrived");
            void'(expected_results.pop_front());
        end
        if (mismatches == 0)
            $display("tb_cell_voltage_fault_qualifier_core: PASS");
        else
            $display("tb_cell_voltage_fault_qualifier_core: FAIL");
        $finish;
    end

endmodule
